>>> sv/pftc_pkg.sv
// ----------------------------------------------------------------------------
// pftc_pkg
// shared constants and types for the prefix formula tautology checker
// ----------------------------------------------------------------------------
`default_nettype none

package pftc_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int TT_W        = 32;

    localparam logic [7:0] SYM_P = 8'h70;  // 'p'
    localparam logic [7:0] SYM_Q = 8'h71;  // 'q'
    localparam logic [7:0] SYM_R = 8'h72;  // 'r'
    localparam logic [7:0] SYM_S = 8'h73;  // 's'
    localparam logic [7:0] SYM_T = 8'h74;  // 't'
    localparam logic [7:0] SYM_N = 8'h4E;  // 'N'
    localparam logic [7:0] SYM_K = 8'h4B;  // 'K'
    localparam logic [7:0] SYM_A = 8'h41;  // 'A'
    localparam logic [7:0] SYM_C = 8'h43;  // 'C'

    localparam logic [TT_W-1:0] MASK_P   = 32'hFFFF_0000;
    localparam logic [TT_W-1:0] MASK_Q   = 32'hFF00_FF00;
    localparam logic [TT_W-1:0] MASK_R   = 32'hF0F0_F0F0;
    localparam logic [TT_W-1:0] MASK_S   = 32'hCCCC_CCCC;
    localparam logic [TT_W-1:0] MASK_T   = 32'hAAAA_AAAA;
    localparam logic [TT_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

    // per-cell move control
    typedef struct packed {
        logic take_above;
        logic take_below;
    } cell_ctrl_t;

endpackage

`default_nettype wire

>>> sv/pftc_cell.sv
// ----------------------------------------------------------------------------
// pftc_cell
// one stack cell: holds a truth table, loads from either neighbour
// ----------------------------------------------------------------------------
`default_nettype none

module pftc_cell (
    input  wire logic                     clk,
    input  wire pftc_pkg::cell_ctrl_t     ctrl,
    input  wire logic [pftc_pkg::TT_W-1:0] above,
    input  wire logic [pftc_pkg::TT_W-1:0] below,
    output logic      [pftc_pkg::TT_W-1:0] data
);
    import pftc_pkg::*;

    logic [TT_W-1:0] data_reg;
    logic [TT_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.take_above)
        begin
            data_next = above;
        end
        else if (ctrl.take_below)
        begin
            data_next = below;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

>>> sv/prefix_formula_tautology_checker.sv
// ----------------------------------------------------------------------------
// prefix_formula_tautology_checker
// tautology check of a prefix formula over p, q, r, s, t
// ----------------------------------------------------------------------------
// Takes one formula character per cycle, last character first, and keeps a
// stack of 32-bit truth tables (one bit per assignment of the five
// variables) in a row of STACK_DEPTH cells, the top of stack in cell 0.
// A push shifts every cell down by one, a binary operator shifts them up
// and drops the result into cell 0, and N inverts cell 0 in place, so the
// cost of each symbol is independent of the stack depth. One transaction is
// accepted every cycle while the output register is free or being drained;
// the transaction flagged last yields one result in the following cycle,
// with malformed raised on underflow, overflow or a final depth other than
// one (tautology is then 0). The stack is cleared logically after the
// last symbol, so the next formula may follow immediately.
// ----------------------------------------------------------------------------
`default_nettype none

module prefix_formula_tautology_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] symbol,
    input  wire logic       last,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            tautology,
    output logic            malformed
);
    import pftc_pkg::*;

    typedef enum logic [1:0] {
        KIND_VAR,
        KIND_NOT,
        KIND_BIN
    } sym_kind_t;

    // stack row
    logic [TT_W-1:0] cell_data [STACK_DEPTH];
    cell_ctrl_t      ctrl_top;
    cell_ctrl_t      ctrl_rest;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             err_reg;
    logic             err_next;

    logic out_valid_reg;
    logic out_valid_next;
    logic taut_reg;
    logic taut_next;
    logic bad_reg;
    logic bad_next;

    logic            accept;
    sym_kind_t       kind;
    logic [TT_W-1:0] push_val;
    logic [TT_W-1:0] bin_val;
    logic [TT_W-1:0] new_top;
    logic [TT_W-1:0] top_after;
    logic            do_push;
    logic            do_not;
    logic            do_pop;
    logic            bad_now;

    // output register free or draining this cycle
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    // symbol decode
    always_comb
    begin
        kind     = KIND_BIN;
        push_val = MASK_P;
        case (symbol)
            SYM_P:   begin kind = KIND_VAR; push_val = MASK_P; end
            SYM_Q:   begin kind = KIND_VAR; push_val = MASK_Q; end
            SYM_R:   begin kind = KIND_VAR; push_val = MASK_R; end
            SYM_S:   begin kind = KIND_VAR; push_val = MASK_S; end
            SYM_T:   begin kind = KIND_VAR; push_val = MASK_T; end
            SYM_N:   kind = KIND_NOT;
            default: kind = KIND_BIN;
        endcase
    end

    // left operand is cell 0, right operand cell 1
    always_comb
    begin
        case (symbol)
            SYM_K:   bin_val = cell_data[0] & cell_data[1];
            SYM_A:   bin_val = cell_data[0] | cell_data[1];
            SYM_C:   bin_val = ~cell_data[0] | cell_data[1];
            default: bin_val = ~(cell_data[0] ^ cell_data[1]);
        endcase
    end

    // legal moves; an illegal one only raises the error flag
    always_comb
    begin
        do_push = 1'b0;
        do_not  = 1'b0;
        do_pop  = 1'b0;
        bad_now = 1'b0;
        new_top = bin_val;
        case (kind)
            KIND_VAR:
            begin
                new_top = push_val;
                if (count_reg < CNT_W'(STACK_DEPTH))
                begin
                    do_push = 1'b1;
                end
                else
                begin
                    bad_now = 1'b1;
                end
            end
            KIND_NOT:
            begin
                new_top = ~cell_data[0];
                if (count_reg >= CNT_W'(1))
                begin
                    do_not = 1'b1;
                end
                else
                begin
                    bad_now = 1'b1;
                end
            end
            default:
            begin
                new_top = bin_val;
                if (count_reg >= CNT_W'(2))
                begin
                    do_pop = 1'b1;
                end
                else
                begin
                    bad_now = 1'b1;
                end
            end
        endcase
    end

    always_comb
    begin
        ctrl_top.take_above  = accept && (do_push || do_not || do_pop);
        ctrl_top.take_below  = 1'b0;
        ctrl_rest.take_above = accept && do_push;
        ctrl_rest.take_below = accept && do_pop;
    end

    // cell 0 takes the new top entry, the rest shift along the row
    pftc_cell u_cell_top (
        .clk   (clk),
        .ctrl  (ctrl_top),
        .above (new_top),
        .below (cell_data[1]),
        .data  (cell_data[0])
    );

    for (genvar i = 1; i < STACK_DEPTH; i++)
    begin : g_cell
        if (i == STACK_DEPTH - 1)
        begin : g_end
            pftc_cell u_cell (
                .clk   (clk),
                .ctrl  (ctrl_rest),
                .above (cell_data[i-1]),
                .below (cell_data[i]),
                .data  (cell_data[i])
            );
        end
        else
        begin : g_mid
            pftc_cell u_cell (
                .clk   (clk),
                .ctrl  (ctrl_rest),
                .above (cell_data[i-1]),
                .below (cell_data[i+1]),
                .data  (cell_data[i])
            );
        end
    end

    // depth, error flag and the result register
    always_comb
    begin
        count_next     = count_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg && out_stall;
        taut_next      = taut_reg;
        bad_next       = bad_reg;
        top_after      = (do_push || do_not || do_pop) ? new_top : cell_data[0];
        if (accept)
        begin
            if (do_push)
            begin
                count_next = count_reg + CNT_W'(1);
            end
            else if (do_pop)
            begin
                count_next = count_reg - CNT_W'(1);
            end
            err_next = err_reg || bad_now;
            if (last)
            begin
                out_valid_next = 1'b1;
                bad_next       = err_next || (count_next != CNT_W'(1));
                taut_next      = !bad_next && (top_after == ALL_ONES);
                count_next     = '0;
                err_next       = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        taut_reg <= taut_next;
        bad_reg  <= bad_next;
    end

    assign out_valid = out_valid_reg;
    assign tautology = taut_reg;
    assign malformed = bad_reg;

endmodule

`default_nettype wire
